// ===== rtl/core/led_swp_pkg.sv =====
package led_swp_pkg;

    // Field widths
    localparam int TS_W    = 32;
    localparam int IDX_W   = 10;
    localparam int COLOR_W = 8;
    localparam int Q16_W   = 17;
    localparam int PHASE_W = 32;
    localparam int PROD_W  = 18;

    // LEDs at or beyond this position are dark
    localparam int MAX_LEDS = 1024;

    localparam logic [Q16_W-1:0] Q16_ONE = 17'd65536;

    // Odd polynomial for sin(pi/2 * u), u in Q16
    localparam longint unsigned POLY_A1 = 102944;
    localparam longint unsigned POLY_A3 = 42178;
    localparam longint unsigned POLY_A5 = 4770;

    // Job queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Register map, word index
    typedef enum logic [2:0] {
        REG_AMPLITUDE    = 3'd0,
        REG_OFFSET       = 3'd1,
        REG_SPATIAL_STEP = 3'd2,
        REG_PHASE_STEP   = 3'd3,
        REG_REVERSE      = 3'd4,
        REG_BASE_RED     = 3'd5,
        REG_BASE_GREEN   = 3'd6,
        REG_BASE_BLUE    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [Q16_W-1:0]   amplitude;
        logic [Q16_W-1:0]   offset;
        logic [PHASE_W-1:0] spatial_step;
        logic [PHASE_W-1:0] phase_step;
        logic               reverse;
        logic [COLOR_W-1:0] base_red;
        logic [COLOR_W-1:0] base_green;
        logic [COLOR_W-1:0] base_blue;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        amplitude:    17'd32768,
        offset:       17'd32768,
        spatial_step: 32'd429496730,
        phase_step:   32'd4294967,
        reverse:      1'b0,
        base_red:     8'd255,
        base_green:   8'd255,
        base_blue:    8'd255
    };

    // One classified LED request: final wave angle and its position
    typedef struct packed {
        logic [PHASE_W-1:0] angle;
        logic [IDX_W-1:0]   index;
    } job_t;

    // Quarter-wave table entry k, Q1.16; evaluated at elaboration only
    function automatic logic [Q16_W-1:0] quarter_sine(input int k, input int tb);
        longint unsigned u;
        longint unsigned u2;
        longint unsigned inner;
        longint unsigned s;
        longint unsigned res;
        u     = longint'(k) << (18 - tb);
        u2    = (u * u) >> 16;
        inner = POLY_A3 - ((POLY_A5 * u2) >> 16);
        s     = POLY_A1 - ((u2 * inner) >> 16);
        res   = (u * s) >> 16;
        return res[Q16_W-1:0];
    endfunction

endpackage

// ===== rtl/core/led_swp_ifs.sv =====
interface led_swp_in_if
    import led_swp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [TS_W-1:0]  timestamp_ms;
    logic             frame_start;
    logic [IDX_W-1:0] led_index;

    modport source (output valid, output timestamp_ms, output frame_start,
                    output led_index, input ready);
    modport sink (input valid, input timestamp_ms, input frame_start,
                  input led_index, output ready);
endinterface

interface led_swp_out_if
    import led_swp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   pixel_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;

    modport source (output valid, output pixel_index, output red, output green,
                    output blue, input ready);
    modport sink (input valid, input pixel_index, input red, input green,
                  input blue, output ready);
endinterface

// ===== rtl/core/led_sine_wave_pattern.sv =====
// Channel   Role   Payload
// pix_in    sink   timestamp_ms[31:0], frame_start, led_index[9:0]
// pix_out   source pixel_index[9:0], red[7:0], green[7:0], blue[7:0]
// APB       slave  8 x 32-bit registers at byte address 4*i
//
// The front takes an item in F_IDLE; on a frame start its sequencer then runs
// F_ADV (phase advance multiply) and F_PHASE (phase update) before F_PUSH forms
// the LED angle; no new item is taken until F_PUSH pushes the job. The back is
// a 4-stage pipeline (table, amplitude multiply, clamp, color multiply).
// rst_n clears phase, last time, queue and valids; registers return to defaults.
// A stall on pix_out freezes the back; the 4-deep queue lets the front run on.
module led_sine_wave_pattern
    import led_swp_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 10
)
(
    input  logic          clk,
    input  logic          rst_n,
    led_swp_in_if.sink    pix_in,
    led_swp_out_if.source pix_out,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    cfg_t     cfg_reg, cfg_next;
    cfg_reg_t reg_sel;
    logic     wr_en;
    logic     push;
    logic     full;
    logic     pop;
    logic     empty;
    job_t     wr_job;
    job_t     rd_job;

    assign pready  = 1'b1;
    assign reg_sel = cfg_reg_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_AMPLITUDE:    cfg_next.amplitude    = pwdata[Q16_W-1:0];
                REG_OFFSET:       cfg_next.offset       = pwdata[Q16_W-1:0];
                REG_SPATIAL_STEP: cfg_next.spatial_step = pwdata;
                REG_PHASE_STEP:   cfg_next.phase_step   = pwdata;
                REG_REVERSE:      cfg_next.reverse      = pwdata[0];
                REG_BASE_RED:     cfg_next.base_red     = pwdata[COLOR_W-1:0];
                REG_BASE_GREEN:   cfg_next.base_green   = pwdata[COLOR_W-1:0];
                REG_BASE_BLUE:    cfg_next.base_blue    = pwdata[COLOR_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (reg_sel)
            REG_AMPLITUDE:    prdata = 32'(cfg_reg.amplitude);
            REG_OFFSET:       prdata = 32'(cfg_reg.offset);
            REG_SPATIAL_STEP: prdata = cfg_reg.spatial_step;
            REG_PHASE_STEP:   prdata = cfg_reg.phase_step;
            REG_REVERSE:      prdata = 32'(cfg_reg.reverse);
            REG_BASE_RED:     prdata = 32'(cfg_reg.base_red);
            REG_BASE_GREEN:   prdata = 32'(cfg_reg.base_green);
            REG_BASE_BLUE:    prdata = 32'(cfg_reg.base_blue);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    led_swp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .pix_in (pix_in),
        .push   (push),
        .job    (wr_job),
        .full   (full)
    );

    led_swp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .full   (full),
        .pop    (pop),
        .rd_job (rd_job),
        .empty  (empty)
    );

    led_swp_back #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .rd_job  (rd_job),
        .empty   (empty),
        .pop     (pop),
        .pix_out (pix_out)
    );

endmodule

// ===== rtl/core/led_swp_front.sv =====
module led_swp_front
    import led_swp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    led_swp_in_if.sink   pix_in,
    output logic         push,
    output job_t         job,
    input  logic         full
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_ADV,
        F_PHASE,
        F_PUSH
    } state_t;

    state_t             state_reg, state_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [TS_W-1:0]    last_time_reg, last_time_next;
    logic [TS_W-1:0]    delta_reg, delta_next;
    logic [PHASE_W-1:0] adv_reg, adv_next;
    logic [PHASE_W-1:0] idxmul_reg, idxmul_next;
    logic [IDX_W-1:0]   index_reg, index_next;
    logic               accept;

    assign pix_in.ready = (state_reg == F_IDLE);
    assign accept       = pix_in.valid && pix_in.ready;

    // Job leaves once the phase is settled and the queue is not full
    assign push      = (state_reg == F_PUSH) && !full;
    assign job.angle = idxmul_reg + phase_reg;
    assign job.index = index_reg;

    // Next-state and datapath
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        last_time_next = last_time_reg;
        delta_next     = delta_reg;
        adv_next       = adv_reg;
        idxmul_next    = idxmul_reg;
        index_next     = index_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    index_next  = pix_in.led_index;
                    idxmul_next = cfg.spatial_step * PHASE_W'(pix_in.led_index);
                    if (pix_in.frame_start)
                    begin
                        // no elapsed time while the last frame-start time is zero
                        delta_next     = (last_time_reg == '0) ? '0
                                         : pix_in.timestamp_ms - last_time_reg;
                        last_time_next = pix_in.timestamp_ms;
                        state_next     = F_ADV;
                    end
                    else
                    begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_ADV:
            begin
                adv_next   = cfg.phase_step * delta_reg;
                state_next = F_PHASE;
            end
            F_PHASE:
            begin
                phase_next = cfg.reverse ? phase_reg - adv_reg : phase_reg + adv_reg;
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // State, phase and job payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            phase_reg     <= '0;
            last_time_reg <= '0;
            delta_reg     <= '0;
            adv_reg       <= '0;
            idxmul_reg    <= '0;
            index_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            last_time_reg <= last_time_next;
            delta_reg     <= delta_next;
            adv_reg       <= adv_next;
            idxmul_reg    <= idxmul_next;
            index_reg     <= index_next;
        end
    end

endmodule

// ===== rtl/core/led_swp_queue.sv =====
module led_swp_queue
    import led_swp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wr_job,
    output logic full,
    input  logic pop,
    output job_t rd_job,
    output logic empty
);

    job_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_job  = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// ===== rtl/core/led_swp_back.sv =====
module led_swp_back
    import led_swp_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 10
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  job_t          rd_job,
    input  logic          empty,
    output logic          pop,
    led_swp_out_if.source pix_out
);

    localparam int TB     = SINE_TABLE_BITS;
    localparam int QSIZE  = 1 << (TB - 2);
    localparam int ADDR_W = TB - 1;

    logic [Q16_W-1:0]   sine_rom [QSIZE+1];
    logic [TB-1:0]      tidx;
    logic [TB-3:0]      k;
    logic [ADDR_W-1:0]  rom_addr;
    logic               en;
    logic [PROD_W+1:0]  sum_w;
    logic [Q16_W-1:0]   bright_w;
    logic [24:0]        red_w;
    logic [24:0]        green_w;
    logic [24:0]        blue_w;
    logic               dark;

    logic               v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic [Q16_W-1:0]   mag1_reg;
    logic               neg1_reg, neg2_reg;
    logic [IDX_W-1:0]   idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic [PROD_W-1:0]  prod2_reg;
    logic [Q16_W-1:0]   bright3_reg;
    logic [COLOR_W-1:0] red4_reg, green4_reg, blue4_reg;

    // Quarter-wave table, constant per entry
    for (genvar g = 0; g <= QSIZE; g++)
    begin : g_rom
        assign sine_rom[g] = quarter_sine(g, TB);
    end

    // Whole pipe moves when the output register can take a new item
    assign en  = !out_valid_reg || pix_out.ready;
    assign pop = en && !empty;

    // Table address: odd quadrants mirror
    assign tidx     = rd_job.angle[PHASE_W-1 -: TB];
    assign k        = tidx[TB-3:0];
    assign rom_addr = tidx[TB-2] ? ADDR_W'(QSIZE) - {1'b0, k} : {1'b0, k};

    // Signed offset plus product, clamped to 0..1.0
    always_comb
    begin
        sum_w    = '0;
        bright_w = '0;
        if (neg2_reg)
        begin
            if ((PROD_W+2)'(prod2_reg) <= (PROD_W+2)'(cfg.offset))
            begin
                sum_w = (PROD_W+2)'(cfg.offset) - (PROD_W+2)'(prod2_reg);
            end
        end
        else
        begin
            sum_w = (PROD_W+2)'(cfg.offset) + (PROD_W+2)'(prod2_reg);
        end
        bright_w = (sum_w > (PROD_W+2)'(Q16_ONE)) ? Q16_ONE : sum_w[Q16_W-1:0];
    end

    // Color scaling
    assign red_w   = 25'(cfg.base_red) * 25'(bright3_reg);
    assign green_w = 25'(cfg.base_green) * 25'(bright3_reg);
    assign blue_w  = 25'(cfg.base_blue) * 25'(bright3_reg);
    assign dark    = 32'(idx3_reg) >= 32'(MAX_LEDS);

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= !empty;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg    <= sine_rom[rom_addr];
            neg1_reg    <= tidx[TB-1];
            idx1_reg    <= rd_job.index;
            prod2_reg   <= PROD_W'((34'(cfg.amplitude) * 34'(mag1_reg)) >> 16);
            neg2_reg    <= neg1_reg;
            idx2_reg    <= idx1_reg;
            bright3_reg <= bright_w;
            idx3_reg    <= idx2_reg;
            idx4_reg    <= idx3_reg;
            red4_reg    <= dark ? '0 : red_w[23:16];
            green4_reg  <= dark ? '0 : green_w[23:16];
            blue4_reg   <= dark ? '0 : blue_w[23:16];
        end
    end

    assign pix_out.valid       = out_valid_reg;
    assign pix_out.pixel_index = idx4_reg;
    assign pix_out.red         = red4_reg;
    assign pix_out.green       = green4_reg;
    assign pix_out.blue        = blue4_reg;

endmodule

// ===== dv/led_sine_wave_pattern_tb.sv =====
`default_nettype none

module led_sine_wave_pattern_tb
    import led_swp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WAVE_BITS  = 10;
    localparam int QUARTER    = 1 << (WAVE_BITS - 2);
    localparam int PHASES     = 8;
    localparam int PHASE_ITEMS = 75;
    localparam int HOLD_CYCLES = 150;

    // One color result for one LED
    typedef struct {
        logic [IDX_W-1:0]   pixel_index;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } pixel_t;

    // Wave color predictor and store of pending pixels
    class led_color_scoreboard;
        cfg_t                cfg;
        logic [PHASE_W-1:0]  phase;
        logic [TS_W-1:0]     last_ms;
        longint unsigned     qsine[QUARTER + 1];
        pixel_t              pending_px[$];
        int                  errors;

        function new();
            longint unsigned u;
            longint unsigned u2;
            longint unsigned inner;
            longint unsigned s;
            // quarter-wave table, Q1.16
            for (int k = 0; k <= QUARTER; k++) begin
                u = k;
                u = u << (18 - WAVE_BITS);
                u2 = (u * u) >> 16;
                inner = POLY_A3 - ((POLY_A5 * u2) >> 16);
                s = POLY_A1 - ((u2 * inner) >> 16);
                qsine[k] = (u * s) >> 16;
            end
            cfg = CFG_RESET;
            phase = '0;
            last_ms = '0;
            errors = 0;
        endfunction

        function void set_reg(cfg_reg_t r, logic [31:0] v);
            case (r)
                REG_AMPLITUDE:    cfg.amplitude = v[Q16_W-1:0];
                REG_OFFSET:       cfg.offset = v[Q16_W-1:0];
                REG_SPATIAL_STEP: cfg.spatial_step = v;
                REG_PHASE_STEP:   cfg.phase_step = v;
                REG_REVERSE:      cfg.reverse = v[0];
                REG_BASE_RED:     cfg.base_red = v[COLOR_W-1:0];
                REG_BASE_GREEN:   cfg.base_green = v[COLOR_W-1:0];
                REG_BASE_BLUE:    cfg.base_blue = v[COLOR_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the wave on a frame start, then color the LED
        function void note_request(logic [TS_W-1:0] ts, logic fs, logic [IDX_W-1:0] idx);
            logic [PHASE_W-1:0] delta;
            logic [PHASE_W-1:0] adv;
            logic [PHASE_W-1:0] angle;
            logic [WAVE_BITS-1:0] pos;
            logic [1:0] quad;
            int k;
            longint unsigned mag;
            longint unsigned prod;
            longint unsigned b;
            longint bright;
            pixel_t px;
            if (fs) begin
                delta = (last_ms == 0) ? '0 : ts - last_ms;
                adv = cfg.phase_step * delta;
                last_ms = ts;
                phase = cfg.reverse ? phase - adv : phase + adv;
            end
            angle = idx * cfg.spatial_step + phase;
            pos = angle[PHASE_W-1 -: WAVE_BITS];
            quad = pos[WAVE_BITS-1 -: 2];
            k = pos[WAVE_BITS-3:0];
            mag = quad[0] ? qsine[QUARTER - k] : qsine[k];
            prod = (64'(cfg.amplitude) * mag) >> 16;
            bright = quad[1] ? longint'(cfg.offset) - longint'(prod)
                             : longint'(cfg.offset) + longint'(prod);
            // saturate to 0..1.0
            if (bright < 0)
                bright = 0;
            if (bright > longint'(Q16_ONE))
                bright = longint'(Q16_ONE);
            b = bright;
            px.pixel_index = idx;
            if (int'(idx) >= MAX_LEDS) begin
                px.red = '0;
                px.green = '0;
                px.blue = '0;
            end
            else begin
                px.red = 8'((64'(cfg.base_red) * b) >> 16);
                px.green = 8'((64'(cfg.base_green) * b) >> 16);
                px.blue = 8'((64'(cfg.base_blue) * b) >> 16);
            end
            pending_px.push_back(px);
        endfunction

        function void check_pixel(logic [IDX_W-1:0] idx, logic [COLOR_W-1:0] r,
                                  logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] bl);
            pixel_t px;
            if (pending_px.size() == 0) begin
                $error("pixel %0d arrived with none pending", idx);
                errors++;
                return;
            end
            px = pending_px.pop_front();
            if (idx !== px.pixel_index) begin
                $error("pixel_index: expected %0d, got %0d", px.pixel_index, idx);
                errors++;
            end
            if (r !== px.red) begin
                $error("red: expected %0d, got %0d", px.red, r);
                errors++;
            end
            if (g !== px.green) begin
                $error("green: expected %0d, got %0d", px.green, g);
                errors++;
            end
            if (bl !== px.blue) begin
                $error("blue: expected %0d, got %0d", px.blue, bl);
                errors++;
            end
        endfunction

        function int pending();
            return pending_px.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    led_swp_in_if  pix_in_bus ();
    led_swp_out_if pix_out_bus ();

    led_color_scoreboard sb;

    // stimulus controls; recv_no_stall and hold_request are shared with the pixel receiver
    bit              send_no_gap;
    bit              recv_no_stall;
    bit              hold_request;
    logic [TS_W-1:0] now_ms;
    int              items_sent;

    led_sine_wave_pattern uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_bus),
        .pix_out (pix_out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'd65536;
            2: return $urandom_range(65537, 131071);
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    function automatic logic [31:0] rand_step();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 32'h00FF_FFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_color();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'd255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // APB write: setup, access, then back to idle; called on a rising edge
    task automatic apb_write(cfg_reg_t r, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(r, v);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one LED request and hold it until taken
    task automatic send_item(logic [TS_W-1:0] ts, logic fs, logic [IDX_W-1:0] idx);
        int gap;
        gap = send_no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            pix_in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_in_bus.valid <= 1'b1;
        pix_in_bus.timestamp_ms <= ts;
        pix_in_bus.frame_start <= fs;
        pix_in_bus.led_index <= idx;
        do
            @(posedge clk);
        while (!pix_in_bus.ready);
        sb.note_request(ts, fs, idx);
        items_sent++;
    endtask

    // Let every pending pixel drain
    task automatic wait_idle();
        pix_in_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // One frame: a frame start followed by consecutive LEDs, or a stray item
    task automatic send_frame();
        int len;
        logic [IDX_W-1:0] first;
        if ($urandom_range(0, 99) < 15) begin
            send_item($urandom, 1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 1023)));
            return;
        end
        if ($urandom_range(0, 19) == 0)
            now_ms = $urandom;
        else
            now_ms = now_ms + $urandom_range(1, 60);
        first = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 1023)) : '0;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 30);
        send_item(now_ms, 1'b1, first);
        for (int k = 1; k < len; k++)
            send_item($urandom, 1'b0, first + IDX_W'(k));
    endtask

    task automatic configure(int p);
        if (p == 0) begin
            apb_write(REG_AMPLITUDE, 32'd65536);
            apb_write(REG_OFFSET, 32'd0);
            apb_write(REG_SPATIAL_STEP, 32'hFFFF_FFFF);
            apb_write(REG_PHASE_STEP, 32'hFFFF_FFFF);
            apb_write(REG_REVERSE, 32'd1);
            apb_write(REG_BASE_RED, 32'd255);
            apb_write(REG_BASE_GREEN, 32'd0);
            apb_write(REG_BASE_BLUE, 32'd128);
        end
        else if (p == 1) begin
            apb_write(REG_AMPLITUDE, 32'd0);
            apb_write(REG_OFFSET, 32'd65536);
            apb_write(REG_SPATIAL_STEP, 32'd0);
            apb_write(REG_PHASE_STEP, 32'd0);
            apb_write(REG_REVERSE, 32'd0);
            apb_write(REG_BASE_RED, 32'd0);
            apb_write(REG_BASE_GREEN, 32'd255);
            apb_write(REG_BASE_BLUE, 32'd1);
        end
        else begin
            apb_write(REG_AMPLITUDE, rand_q16());
            apb_write(REG_OFFSET, rand_q16());
            apb_write(REG_SPATIAL_STEP, rand_step());
            apb_write(REG_PHASE_STEP, rand_step());
            apb_write(REG_REVERSE, $urandom_range(0, 1));
            apb_write(REG_BASE_RED, rand_color());
            apb_write(REG_BASE_GREEN, rand_color());
            apb_write(REG_BASE_BLUE, rand_color());
        end
    endtask

    // Pixel receiver: checks results and drives ready
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        pix_out_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (pix_out_bus.valid && pix_out_bus.ready)
                sb.check_pixel(pix_out_bus.pixel_index, pix_out_bus.red,
                               pix_out_bus.green, pix_out_bus.blue);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pix_out_bus.ready <= 1'b0;
            end
            else if (recv_no_stall) begin
                pix_out_bus.ready <= 1'b1;
            end
            else if (stall_left > 0) begin
                stall_left--;
                pix_out_bus.ready <= 1'b0;
            end
            else if ($urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
                pix_out_bus.ready <= 1'b0;
            end
            else begin
                pix_out_bus.ready <= 1'b1;
            end
        end
    end

    // Main stimulus
    initial begin
        int phase_start;
        sb = new();
        send_no_gap = 1'b0;
        recv_no_stall = 1'b0;
        hold_request = 1'b0;
        items_sent = 0;
        now_ms = $urandom;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        pix_in_bus.valid <= 1'b0;
        pix_in_bus.timestamp_ms <= '0;
        pix_in_bus.frame_start <= 1'b0;
        pix_in_bus.led_index <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero time, first frame, backward and wrapping time, index extremes
        send_item(32'd0, 1'b1, 10'd0);
        send_item(32'd100, 1'b1, 10'd1);
        send_item(32'd200, 1'b1, 10'd1023);
        send_item(32'hFFFF_FFFF, 1'b0, 10'd0);
        send_item(32'd50, 1'b1, 10'd512);
        send_item(32'hFFFF_FFFF, 1'b1, 10'd1023);
        send_item(32'd5, 1'b1, 10'h155);
        send_item(32'd0, 1'b1, 10'h2AA);
        send_item(32'd1000, 1'b1, 10'd3);
        send_item(32'd1250, 1'b1, 10'd256);
        for (int k = 0; k < 10; k++)
            send_item($urandom, 1'b0, IDX_W'(k * 103));
        send_item(32'hAAAA_5555, 1'b1, 10'd768);
        send_item(32'h5555_AAAA, 1'b1, 10'd1022);
        wait_idle();

        // phases 0 and 1 use fixed settings, the rest random; one register setting each
        for (int p = 0; p < PHASES; p++) begin
            configure(p);
            send_no_gap = (p == 3) || (p == 2);
            recv_no_stall = (p == 3);
            if (p == 2)
                hold_request = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                send_frame();
                if (p == 2 && items_sent - phase_start > 60)
                    send_no_gap = 1'b0;
                if (p == 4 && items_sent - phase_start > PHASE_ITEMS / 2
                    && items_sent - phase_start < PHASE_ITEMS / 2 + 10)
                    wait_idle();
            end
            send_no_gap = 1'b0;
            recv_no_stall = 1'b0;
            wait_idle();
        end

        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/led_swp_pkg.sv
rtl/core/led_swp_ifs.sv
rtl/core/led_swp_front.sv
rtl/core/led_swp_queue.sv
rtl/core/led_swp_back.sv
rtl/core/led_sine_wave_pattern.sv
dv/led_sine_wave_pattern_tb.sv
